// ===== src/json_string_escaper_utf8_assert.svh =====
// Assertion macros used by the top module to check its own behavior.
`ifndef JSON_STRING_ESCAPER_UTF8_ASSERT_SVH
`define JSON_STRING_ESCAPER_UTF8_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JSEU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define JSEU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/jseu_pkg.sv =====
`timescale 1ns / 1ps

package jseu_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_end;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
    } t_out;

    typedef struct packed {
        logic [20:0] acc;
        logic [1:0]  expected;
        logic [1:0]  seen;
        logic        open;
    } t_state;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_ONE,
        KIND_ESC
    } t_kind;

    typedef enum logic [2:0] {
        SEG_OPEN,
        SEG_UNIT,
        SEG_CHAR,
        SEG_CLOSE,
        SEG_DONE
    } t_seg;

    // Characters of one input item: optional opening quote, a run of \uXXXX
    // units (replacements first, then up to two decoded units), an optional
    // plain or backslash-escaped character, and an optional closing quote.
    typedef struct packed {
        logic        open;
        logic [2:0]  n_repl;
        logic [1:0]  n_body;
        logic [15:0] u0;
        logic [15:0] u1;
        t_kind       kind;
        logic [7:0]  ch;
        logic        close;
    } t_plan;

    localparam logic [7:0]  CH_QUOTE     = 8'h22;
    localparam logic [7:0]  CH_BSLASH    = 8'h5C;
    localparam logic [7:0]  CH_U         = 8'h75;
    localparam logic [7:0]  CH_SPACE     = 8'h20;
    localparam logic [7:0]  CH_DEL       = 8'h7F;
    localparam logic [7:0]  LEAD2_MIN    = 8'hC2;
    localparam logic [7:0]  LEAD2_MAX    = 8'hDF;
    localparam logic [7:0]  LEAD3_MIN    = 8'hE0;
    localparam logic [7:0]  LEAD3_MAX    = 8'hEF;
    localparam logic [7:0]  LEAD4_MIN    = 8'hF0;
    localparam logic [7:0]  LEAD4_MAX    = 8'hF4;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] CP_BMP_MAX   = 21'h00FFFF;
    localparam logic [20:0] SURR_LO      = 21'h00D800;
    localparam logic [20:0] SURR_HI      = 21'h00DFFF;
    localparam logic [20:0] SUPP_BASE    = 21'h010000;
    localparam logic [20:0] MIN_TWO      = 21'h000080;
    localparam logic [20:0] MIN_THREE    = 21'h000800;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
    localparam logic [15:0] REPL_UNIT    = 16'hFFFD;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        hex_char = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h57 + {4'h0, nib});
    endfunction

endpackage

// ===== src/jseu_decode.sv =====
`timescale 1ns / 1ps

module jseu_decode import jseu_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_accept,
    input  t_in    i_item,
    output t_plan  o_plan,
    output logic   o_nonempty,
    output t_state o_state
);

    t_state      r_st;
    t_state      n_st;
    t_plan       plan;
    logic [7:0]  c;
    logic        taken;
    logic [20:0] acc_n;
    logic [1:0]  seen_n;
    logic [20:0] minimum;
    logic [20:0] cp_off;

    always_comb begin
        n_st    = r_st;
        plan    = '0;
        c       = i_item.in_byte;
        taken   = 1'b0;
        acc_n   = {r_st.acc[14:0], c[5:0]};
        seen_n  = r_st.seen + 2'd1;
        minimum = SUPP_BASE;
        cp_off  = acc_n - SUPP_BASE;

        plan.open  = !r_st.open;
        n_st.open  = 1'b1;
        plan.kind  = KIND_NONE;
        plan.ch    = c;

        if (i_item.is_end) begin
            if (r_st.expected != 2'd0) begin
                plan.n_repl = {1'b0, r_st.seen} + 3'd1;
            end
            n_st.acc      = '0;
            n_st.expected = '0;
            n_st.seen     = '0;
            plan.close    = 1'b1;
            n_st.open     = 1'b0;
        end else begin
            if (r_st.expected != 2'd0) begin
                if (c[7:6] == 2'b10) begin
                    taken = 1'b1;
                    if (seen_n >= r_st.expected) begin
                        unique case (r_st.expected)
                            2'd1:    minimum = MIN_TWO;
                            2'd2:    minimum = MIN_THREE;
                            default: minimum = SUPP_BASE;
                        endcase
                        if (acc_n < minimum || acc_n > CP_MAX ||
                            (acc_n >= SURR_LO && acc_n <= SURR_HI)) begin
                            plan.n_repl = {1'b0, r_st.expected} + 3'd1;
                        end else if (acc_n <= CP_BMP_MAX) begin
                            plan.n_body = 2'd1;
                            plan.u0     = acc_n[15:0];
                        end else begin
                            plan.n_body = 2'd2;
                            plan.u0     = HI_SURR_BASE + {6'h00, cp_off[19:10]};
                            plan.u1     = LO_SURR_BASE + {6'h00, cp_off[9:0]};
                        end
                        n_st.acc      = '0;
                        n_st.expected = '0;
                        n_st.seen     = '0;
                    end else begin
                        n_st.acc  = acc_n;
                        n_st.seen = seen_n;
                    end
                end else begin
                    plan.n_repl   = {1'b0, r_st.seen} + 3'd1;
                    n_st.acc      = '0;
                    n_st.expected = '0;
                    n_st.seen     = '0;
                end
            end
            if (!taken) begin
                if (c == CH_QUOTE || c == CH_BSLASH) begin
                    plan.kind = KIND_ESC;
                end else if (c < CH_SPACE || c == CH_DEL) begin
                    plan.n_body = 2'd1;
                    plan.u0     = {8'h00, c};
                end else if (c[7] == 1'b0) begin
                    plan.kind = KIND_ONE;
                end else if (c >= LEAD2_MIN && c <= LEAD2_MAX) begin
                    n_st.acc      = {16'h0000, c[4:0]};
                    n_st.expected = 2'd1;
                    n_st.seen     = 2'd0;
                end else if (c >= LEAD3_MIN && c <= LEAD3_MAX) begin
                    n_st.acc      = {17'h00000, c[3:0]};
                    n_st.expected = 2'd2;
                    n_st.seen     = 2'd0;
                end else if (c >= LEAD4_MIN && c <= LEAD4_MAX) begin
                    n_st.acc      = {18'h00000, c[2:0]};
                    n_st.expected = 2'd3;
                    n_st.seen     = 2'd0;
                end else begin
                    plan.n_repl = plan.n_repl + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_accept) begin
            r_st <= n_st;
        end
    end

    assign o_plan     = plan;
    assign o_nonempty = plan.open || (plan.n_repl != 3'd0) || (plan.n_body != 2'd0) ||
                        (plan.kind != KIND_NONE) || plan.close;
    assign o_state    = r_st;

endmodule

// ===== src/jseu_emit.sv =====
`timescale 1ns / 1ps

module jseu_emit import jseu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  t_plan i_plan,
    input  logic  i_stall,
    output logic  o_hold,
    output logic  o_busy,
    output logic  o_valid,
    output t_out  o_data
);

    function automatic logic [2:0] unit_count(input t_plan p);
        unit_count = p.n_repl + {1'b0, p.n_body};
    endfunction

    function automatic t_seg next_after(input t_plan p, input t_seg s);
        t_seg r;
        r = SEG_DONE;
        unique case (s)
            SEG_OPEN: begin
                if (unit_count(p) != 3'd0) r = SEG_UNIT;
                else if (p.kind != KIND_NONE) r = SEG_CHAR;
                else if (p.close) r = SEG_CLOSE;
            end
            SEG_UNIT: begin
                if (p.kind != KIND_NONE) r = SEG_CHAR;
                else if (p.close) r = SEG_CLOSE;
            end
            SEG_CHAR: begin
                if (p.close) r = SEG_CLOSE;
            end
            default: r = SEG_DONE;
        endcase
        return r;
    endfunction

    logic        r_plan_valid;
    t_plan       r_plan;
    t_seg        r_seg;
    logic [2:0]  r_pos;
    logic [1:0]  r_unit;
    logic        r_out_valid;
    t_out        r_out;

    logic        out_free;
    logic        adv;
    logic [7:0]  ch;
    logic        seg_end;
    logic        unit_more;
    logic        fin;
    t_seg        n_seg;
    t_seg        load_seg;
    logic [15:0] unit_val;
    logic [2:0]  unit_rel;

    assign out_free = !r_out_valid || !i_stall;
    assign adv      = r_plan_valid && out_free;
    assign load_seg = i_plan.open ? SEG_OPEN : next_after(i_plan, SEG_OPEN);

    always_comb begin
        ch        = '0;
        seg_end   = 1'b0;
        unit_more = 1'b0;
        unit_rel  = {1'b0, r_unit} - r_plan.n_repl;
        if ({1'b0, r_unit} < r_plan.n_repl) begin
            unit_val = REPL_UNIT;
        end else if (unit_rel == 3'd0) begin
            unit_val = r_plan.u0;
        end else begin
            unit_val = r_plan.u1;
        end

        unique case (r_seg)
            SEG_OPEN: begin
                ch      = CH_QUOTE;
                seg_end = 1'b1;
            end
            SEG_UNIT: begin
                unique case (r_pos)
                    3'd0:    ch = CH_BSLASH;
                    3'd1:    ch = CH_U;
                    3'd2:    ch = hex_char(unit_val[15:12]);
                    3'd3:    ch = hex_char(unit_val[11:8]);
                    3'd4:    ch = hex_char(unit_val[7:4]);
                    3'd5:    ch = hex_char(unit_val[3:0]);
                    default: ch = '0;
                endcase
                if (r_pos == 3'd5) begin
                    if (({1'b0, r_unit} + 3'd1) < unit_count(r_plan)) begin
                        unit_more = 1'b1;
                    end else begin
                        seg_end = 1'b1;
                    end
                end
            end
            SEG_CHAR: begin
                if (r_plan.kind == KIND_ESC && r_pos == 3'd0) begin
                    ch = CH_BSLASH;
                end else begin
                    ch      = r_plan.ch;
                    seg_end = 1'b1;
                end
            end
            SEG_CLOSE: begin
                ch      = CH_QUOTE;
                seg_end = 1'b1;
            end
            default: begin
                ch = '0;
            end
        endcase

        n_seg = seg_end ? next_after(r_plan, r_seg) : r_seg;
        fin   = seg_end && (n_seg == SEG_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plan_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_seg        <= SEG_DONE;
            r_pos        <= '0;
            r_unit       <= '0;
        end else begin
            if (out_free) begin
                r_out_valid <= adv;
            end
            if (i_load) begin
                r_plan_valid <= 1'b1;
                r_seg        <= load_seg;
                r_pos        <= '0;
                r_unit       <= '0;
            end else if (adv) begin
                if (fin) begin
                    r_plan_valid <= 1'b0;
                end else if (unit_more) begin
                    r_unit <= r_unit + 2'd1;
                    r_pos  <= '0;
                end else if (seg_end) begin
                    r_seg <= n_seg;
                    r_pos <= '0;
                end else begin
                    r_pos <= r_pos + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_plan <= i_plan;
        end
        if (adv) begin
            r_out.out_char <= ch;
            r_out.run_last <= fin;
        end
    end

    assign o_hold  = r_plan_valid && !(adv && fin);
    assign o_busy  = r_plan_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== src/json_string_escaper_utf8.sv =====
// Latency: the plan of an accepted item is registered, and its first character then passes through the output register.
// Throughput: one output character per cycle while i_stall is low; an input item that yields more than one character
// holds o_stall high until its last character is produced, so plain ASCII streams at one byte per cycle.
// The character sequencer, one character per cycle while i_stall is low, sets the rate of escaped items.
// Reset (synchronous, active low) empties both registers, drops any pending UTF-8
// sequence and marks the string as not yet opened.
`timescale 1ns / 1ps

`include "json_string_escaper_utf8_assert.svh"

module json_string_escaper_utf8 import jseu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    logic   accept;
    logic   hold;
    logic   busy;
    logic   nonempty;
    t_plan  plan;
    t_state state;

    assign o_stall = hold;
    assign accept  = i_valid && !hold;

    jseu_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_data),
        .o_plan     (plan),
        .o_nonempty (nonempty),
        .o_state    (state)
    );

    jseu_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept && nonempty),
        .i_plan  (plan),
        .i_stall (i_stall),
        .o_hold  (hold),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    `JSEU_ASSERT_IMPL(a_idle_no_stall, i_clk, i_rst_n, !busy, !o_stall)
    `JSEU_ASSERT_IMPL(a_pending_open, i_clk, i_rst_n, state.expected != 2'd0,
                      state.open && (state.seen < state.expected))
    `JSEU_ASSERT_NEXT(a_end_closes, i_clk, i_rst_n, accept && i_data.is_end,
                      !state.open && (state.expected == 2'd0) && busy)

endmodule
